// ===== rtl/core/isl_pkg.sv =====
// Package for the indexed sequential list: command codes, field widths,
// the record type and the control word broadcast to the cells. No dependencies.
`default_nettype none

package isl_pkg;

   localparam int AGE_W = 8;
   localparam int WGT_W = 16;
   localparam int REC_W = AGE_W + WGT_W;
   localparam int POS_W = 7;
   localparam int CNT_W = 7;
   localparam int CMD_W = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   // Age in the upper byte, weight below it.
   typedef logic [REC_W-1:0] isl_rec_type;

   typedef struct packed {
      logic             ins_go;
      logic             del_go;
      logic [POS_W-1:0] wr_pos;
      logic [POS_W-1:0] rd_pos;
   } isl_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/isl_cell.sv =====
// One storage cell of the list chain: holds one record and trades it with
// its neighbors on insert and delete. Depends on isl_pkg.
`default_nettype none

module isl_cell #(
   parameter int IDX_W = 6
) (
   input  wire                      clock,
   input  wire [IDX_W-1:0]          idx,
   input  isl_pkg::isl_ctl_type     ctl,
   input  isl_pkg::isl_rec_type     new_rec,
   input  isl_pkg::isl_rec_type     left_rec,
   input  isl_pkg::isl_rec_type     right_rec,
   output isl_pkg::isl_rec_type     rec,
   output isl_pkg::isl_rec_type     leaf
);
   import isl_pkg::*;

   localparam int CW = (IDX_W > POS_W) ? IDX_W : POS_W;

   logic [CW-1:0] idx_ext;
   logic [CW-1:0] wr_ext;
   logic [CW-1:0] rd_ext;
   isl_rec_type   rec_ff;
   isl_rec_type   rec_in;

   assign idx_ext = CW'(idx);
   assign wr_ext  = CW'(ctl.wr_pos);
   assign rd_ext  = CW'(ctl.rd_pos);

   always_comb begin
      rec_in = rec_ff;
      if (ctl.ins_go && idx_ext > wr_ext) begin
         rec_in = left_rec;
      end else if (ctl.ins_go && idx_ext == wr_ext) begin
         rec_in = new_rec;
      end else if (ctl.del_go && idx_ext >= wr_ext) begin
         rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec  = rec_ff;
   assign leaf = (idx_ext == rd_ext) ? rec_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/core/isl_read_tree.sv =====
// Registered OR tree that gathers the one selected record out of the cells,
// one tree level per clock. Depends on isl_pkg.
`default_nettype none

module isl_read_tree #(
   parameter int DEPTH = 64
) (
   input  wire                  clock,
   input  isl_pkg::isl_rec_type leaf [DEPTH],
   output isl_pkg::isl_rec_type root
);
   import isl_pkg::*;

   localparam int LVLS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int P    = 1 << LVLS;

   isl_rec_type lp      [P];
   isl_rec_type node_ff [1:P-1];

   for (genvar gl = 0; gl < P; gl++) begin : g_pad
      if (gl < DEPTH) begin : g_real
         assign lp[gl] = leaf[gl];
      end else begin : g_zero
         assign lp[gl] = '0;
      end
   end

   for (genvar gn = 1; gn < P; gn++) begin : g_node
      if (2 * gn >= P) begin : g_bottom
         always_ff @(posedge clock) begin
            node_ff[gn] <= lp[2*gn-P] | lp[2*gn+1-P];
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            node_ff[gn] <= node_ff[2*gn] | node_ff[2*gn+1];
         end
      end
   end

   assign root = node_ff[1];

endmodule

`default_nettype wire

// ===== rtl/core/indexed_sequential_list_core.sv =====
// Top level of the indexed sequential list: command decode, length count,
// the chain of record cells and the read tree. Depends on isl_pkg, isl_cell, isl_read_tree.
`default_nettype none

// The block keeps an ordered list of up to DEPTH records (8-bit age, 16-bit
// weight) in a chain of cells, one record per cell. A command word is taken
// when start is high and busy is low. Insert and delete act on every cell in
// the same clock and clear only resets the length; for all three the response
// word appears on the rsp_ ports in the cycle after the command and busy
// stays low. A read that hits a stored entry collects the record through a
// registered OR tree of log2(DEPTH) levels; busy is high while it drains and
// the response appears in the cycle busy falls. Rejected commands (insert
// into a full list or past the end, delete or read at or beyond the length)
// answer in the cycle after with status set and the list left alone. Each
// response is held for exactly one cycle with rsp_valid high; the receiver
// cannot hold it off, so it must take every word as it comes.
// Record contents are not cleared by reset or by the clear command, only the
// length; count reports the length in seven bits.

module indexed_sequential_list_core #(
   parameter int DEPTH = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire [isl_pkg::CMD_W-1:0]    req_cmd,
   input  wire [isl_pkg::POS_W-1:0]    req_position,
   input  wire [isl_pkg::AGE_W-1:0]    req_in_age,
   input  wire [isl_pkg::WGT_W-1:0]    req_in_weight,
   output logic                        rsp_valid,
   output logic                        rsp_status,
   output logic [isl_pkg::AGE_W-1:0]   rsp_out_age,
   output logic [isl_pkg::WGT_W-1:0]   rsp_out_weight,
   output logic [isl_pkg::CNT_W-1:0]   rsp_count,
   output logic                        rsp_empty_res
);
   import isl_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = $clog2(DEPTH + 1);
   localparam int CW    = (LW > POS_W) ? LW : POS_W;
   localparam int LVLS  = IDX_W;
   localparam int RCW   = $clog2(LVLS + 1);

   logic            acc;
   logic [CW-1:0]   pos_ext;
   logic [CW-1:0]   len_ext;
   logic            ins_ok;
   logic            del_ok;
   logic            rd_ok;
   logic            clr_go;

   logic [LW-1:0]   len_ff;
   logic [LW-1:0]   len_in;
   logic [RCW-1:0]  rd_cnt_ff;
   logic [RCW-1:0]  rd_cnt_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            rsp_status_ff;
   logic            rsp_status_in;
   logic            rd_sel_ff;
   logic            rd_sel_in;
   logic [POS_W-1:0] rd_pos_ff;
   logic [POS_W-1:0] rd_pos_in;

   isl_ctl_type     ctl;
   isl_rec_type     new_rec;
   isl_rec_type     rec_w  [DEPTH];
   isl_rec_type     leaf_w [DEPTH];
   isl_rec_type     root;

   // A command is taken only while no read is draining through the tree.
   assign busy = (rd_cnt_ff != '0);
   assign acc  = start && !busy;

   assign pos_ext = CW'(req_position);
   assign len_ext = CW'(len_ff);

   // Insert may append at position equal to the length; delete and read
   // must land on a stored entry, which also rules out an empty list.
   assign ins_ok = acc && (req_cmd == CMD_INSERT) && (len_ff != LW'(DEPTH)) &&
                   (pos_ext <= len_ext);
   assign del_ok = acc && (req_cmd == CMD_DELETE) && (pos_ext < len_ext);
   assign rd_ok  = acc && (req_cmd == CMD_READ) && (pos_ext < len_ext);
   assign clr_go = acc && (req_cmd == CMD_CLEAR);

   always_comb begin
      len_in = len_ff;
      if (clr_go) begin
         len_in = '0;
      end else if (ins_ok) begin
         len_in = len_ff + LW'(1);
      end else if (del_ok) begin
         len_in = len_ff - LW'(1);
      end
   end

   always_comb begin
      rd_cnt_in = rd_cnt_ff;
      if (rd_ok) begin
         rd_cnt_in = RCW'(LVLS);
      end else if (rd_cnt_ff != '0) begin
         rd_cnt_in = rd_cnt_ff - RCW'(1);
      end
   end

   // Every command except a good read answers in the next cycle; a good
   // read answers as the count runs out and the tree root is settled.
   assign rsp_valid_in  = (acc && !rd_ok) || (rd_cnt_ff == RCW'(1));
   assign rsp_status_in = acc ? !(ins_ok || del_ok || rd_ok || clr_go) : rsp_status_ff;
   assign rd_sel_in     = acc ? rd_ok : rd_sel_ff;
   assign rd_pos_in     = rd_ok ? req_position : rd_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         rd_cnt_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= 1'b0;
         rd_sel_ff     <= 1'b0;
      end else begin
         len_ff        <= len_in;
         rd_cnt_ff     <= rd_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rd_sel_ff     <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff <= rd_pos_in;
   end

   assign ctl.ins_go = ins_ok;
   assign ctl.del_go = del_ok;
   assign ctl.wr_pos = req_position;
   assign ctl.rd_pos = rd_pos_ff;
   assign new_rec    = {req_in_age, req_in_weight};

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      isl_rec_type left_w;
      isl_rec_type right_w;

      if (gi == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = rec_w[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = rec_w[gi+1];
      end

      isl_cell #(
         .IDX_W (IDX_W)
      ) u_cell (
         .clock     (clock),
         .idx       (IDX_W'(gi)),
         .ctl       (ctl),
         .new_rec   (new_rec),
         .left_rec  (left_w),
         .right_rec (right_w),
         .rec       (rec_w[gi]),
         .leaf      (leaf_w[gi])
      );
   end

   isl_read_tree #(
      .DEPTH (DEPTH)
   ) u_tree (
      .clock (clock),
      .leaf  (leaf_w),
      .root  (root)
   );

   // Count and empty flag come straight from the length, which already
   // holds the value after the command when the response word is shown.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_age    = rd_sel_ff ? root[REC_W-1:WGT_W] : '0;
   assign rsp_out_weight = rd_sel_ff ? root[WGT_W-1:0] : '0;
   assign rsp_count      = CNT_W'(len_ff);
   assign rsp_empty_res  = (len_ff == '0);

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(DEPTH))
      else $error("list length above depth");

   a_quick_resp : assert property (@(posedge clock) disable iff (reset)
      (acc && !rd_ok) |=> rsp_valid)
      else $error("one-cycle command gave no response word");

   a_no_resp_busy : assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("response word while a read is still in the tree");

   a_read_timing : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rd_sel_ff) |-> ($past(rd_cnt_ff) == RCW'(1)))
      else $error("read response out of step with the tree");

   a_read_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rd_sel_ff) |-> !rsp_status)
      else $error("read data shown on a rejected command");

endmodule

`default_nettype wire
